// File: rtl/core/sidelvl_pkg.sv
`timescale 1ns / 1ps

package sidelvl_pkg;

  // Fixed field widths of the item and result.
  localparam int CMD_W   = 3;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int CNT_W   = 7;
  localparam int TOTAL_W = 38;
  localparam int NOTL_W  = 64;

  localparam int MAX_LEVELS_DEF = 64;
  localparam int MAX_RESULTS    = 64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Command codes carried by an input item.
  localparam logic [CMD_W-1:0] CMD_UPSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CONSUME = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TOP_N   = 3'd5;

  // Operation applied by every cell of the row in the same cycle.
  typedef enum logic [2:0] {
    COP_NONE,
    COP_INSERT,
    COP_DELETE,
    COP_SET_EQ,
    COP_SET_BEST
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FETCH,
    ST_APPLY,
    ST_EMIT
  } state_t;

  // Broadcast from the sequencer to the row of cells.
  typedef struct packed {
    cell_op_t            op;
    logic                look;
    logic                ge_all;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
  } cell_ctrl_t;

endpackage

// File: rtl/core/sidelvl_cell.sv
`timescale 1ns / 1ps

module sidelvl_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                          clk,
  input  sidelvl_pkg::cell_ctrl_t       ctrl,
  input  logic [CW-1:0]                 count,
  input  logic [IW-1:0]                 best_idx,
  input  logic [IW-1:0]                 rd_idx,
  input  logic [sidelvl_pkg::PRICE_W-1:0] left_price,
  input  logic [sidelvl_pkg::QTY_W-1:0]   left_qty,
  input  logic                          left_lt,
  input  logic [sidelvl_pkg::PRICE_W-1:0] right_price,
  input  logic [sidelvl_pkg::QTY_W-1:0]   right_qty,
  output logic [sidelvl_pkg::PRICE_W-1:0] price_o,
  output logic [sidelvl_pkg::QTY_W-1:0]   qty_o,
  output logic                          lt_o,
  output logic                          eq_o,
  output logic [sidelvl_pkg::QTY_W-1:0]   eq_qty_o,
  output logic [sidelvl_pkg::PRICE_W-1:0] top_price_o,
  output logic [sidelvl_pkg::QTY_W-1:0]   best_qty_o,
  output logic [sidelvl_pkg::PRICE_W-1:0] rd_price_o,
  output logic [sidelvl_pkg::QTY_W-1:0]   rd_qty_o
);

  logic [sidelvl_pkg::PRICE_W-1:0] price_r, price_nxt;
  logic [sidelvl_pkg::QTY_W-1:0]   qty_r, qty_nxt;
  logic lt_r, lt_nxt, eq_r, eq_nxt, ge_r, ge_nxt;
  logic occ, is_best, is_rd;

  assign occ     = (CW'(IDX) < count);
  assign is_best = (IW'(IDX) == best_idx);
  assign is_rd   = (IW'(IDX) == rd_idx);

  always_comb begin
    price_nxt = price_r;
    qty_nxt   = qty_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    ge_nxt    = ge_r;
    if (ctrl.look) begin
      lt_nxt = occ && (price_r < ctrl.price);
      eq_nxt = occ && (price_r == ctrl.price);
      ge_nxt = ctrl.ge_all || !lt_nxt;
    end
    case (ctrl.op)
      sidelvl_pkg::COP_INSERT: begin
        if (ge_r) begin
          if (IDX == 0 || left_lt) begin
            price_nxt = ctrl.price;
            qty_nxt   = ctrl.qty;
          end else begin
            price_nxt = left_price;
            qty_nxt   = left_qty;
          end
        end
      end
      sidelvl_pkg::COP_DELETE: begin
        if (ge_r) begin
          price_nxt = right_price;
          qty_nxt   = right_qty;
        end
      end
      sidelvl_pkg::COP_SET_EQ: begin
        if (eq_r) qty_nxt = ctrl.qty;
      end
      sidelvl_pkg::COP_SET_BEST: begin
        if (is_best) qty_nxt = ctrl.qty;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
    ge_r    <= ge_nxt;
  end

  assign price_o      = price_r;
  assign qty_o        = qty_r;
  assign lt_o         = lt_r;
  assign eq_o         = eq_r;
  assign eq_qty_o     = eq_r ? qty_r : '0;
  assign top_price_o  = is_best ? price_r : '0;
  assign best_qty_o   = is_best ? qty_r : '0;
  assign rd_price_o   = is_rd ? price_r : '0;
  assign rd_qty_o     = is_rd ? qty_r : '0;

endmodule

// File: rtl/core/order_book_side_levels_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                                         Direction
// in        in_valid/in_ready, command price quantity count  into the block
// out       out_valid/out_ready, eleven result fields        out of the block
// cfg       cfg_valid/cfg_ready, cfg_book_side               into the block
//
// After an item is accepted it passes through three working states (look, fetch,
// apply), then gives one result per cycle while the output is not stalled: one
// for a plain command, k for top_n with k levels. Reset is synchronous and
// empties the book; cell contents are not cleared. A stalled output holds its
// result and the sequencer waits for it.

module order_book_side_levels_unit #(
  parameter int MAX_LEVELS = sidelvl_pkg::MAX_LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sidelvl_pkg::CMD_W-1:0]    in_command,
  input  logic [sidelvl_pkg::PRICE_W-1:0]  in_price,
  input  logic [sidelvl_pkg::QTY_W-1:0]    in_quantity,
  input  logic [sidelvl_pkg::CNT_W-1:0]    in_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic                             out_best_valid,
  output logic [sidelvl_pkg::PRICE_W-1:0]  out_top_price,
  output logic [sidelvl_pkg::QTY_W-1:0]    out_best_size,
  output logic [sidelvl_pkg::TOTAL_W-1:0]  out_total_quantity,
  output logic [sidelvl_pkg::QTY_W-1:0]    out_consumed,
  output logic [sidelvl_pkg::NOTL_W-1:0]   out_notional,
  output logic                             out_level_valid,
  output logic [sidelvl_pkg::PRICE_W-1:0]  out_level_price,
  output logic [sidelvl_pkg::QTY_W-1:0]    out_level_size,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_book_side
);

  localparam int PW = sidelvl_pkg::PRICE_W;
  localparam int QW = sidelvl_pkg::QTY_W;
  localparam int TW = sidelvl_pkg::TOTAL_W;
  localparam int KW = sidelvl_pkg::CNT_W;
  localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW = $clog2(MAX_LEVELS + 1);
  // The exact sum of all levels never overflows this width.
  localparam int SW = (QW + CW > TW) ? QW + CW : TW + 1;

  // Row of cells and its neighbour wiring.
  sidelvl_pkg::cell_ctrl_t ctrl;
  logic [PW-1:0] c_price [MAX_LEVELS];
  logic [QW-1:0] c_qty   [MAX_LEVELS];
  logic          c_lt    [MAX_LEVELS];
  logic          c_eq    [MAX_LEVELS];
  logic [QW-1:0] c_eqq   [MAX_LEVELS];
  logic [PW-1:0] c_bp    [MAX_LEVELS];
  logic [QW-1:0] c_bq    [MAX_LEVELS];
  logic [PW-1:0] c_rp    [MAX_LEVELS];
  logic [QW-1:0] c_rq    [MAX_LEVELS];
  logic [IW-1:0] best_idx, rd_idx;

  sidelvl_pkg::state_t state_r, state_nxt;
  logic                side_r;
  logic [sidelvl_pkg::CMD_W-1:0] cmd_r;
  logic [PW-1:0]       p_r;
  logic [QW-1:0]       q_r;
  logic [KW-1:0]       n_r;
  logic [CW-1:0]       count_r;
  logic [SW-1:0]       sum_r;
  logic [PW-1:0]       bp_r;
  logic [QW-1:0]       bq_r;

  // Plan built in the fetch cycle and carried out in the apply cycle.
  sidelvl_pkg::cell_op_t op_r, op_nxt;
  logic [QW-1:0]       qv_r, qv_nxt;
  logic [QW-1:0]       sub_r, sub_nxt, add_r, add_nxt;
  logic                status_r, status_nxt;
  logic [QW-1:0]       consumed_r, consumed_nxt;
  logic [sidelvl_pkg::NOTL_W-1:0] notional_r, notional_nxt;
  logic [CW-1:0]       cnt_new_r, cnt_new_nxt;
  logic [KW-1:0]       nres_r, k_r;
  logic                topn_r;

  logic                out_valid_r;
  logic                out_status_r, out_best_valid_r, out_level_valid_r, out_last_r;
  logic [PW-1:0]       out_top_price_r, out_level_price_r;
  logic [QW-1:0]       out_best_size_r, out_level_size_r, out_consumed_r;
  logic [TW-1:0]       out_total_r;
  logic [sidelvl_pkg::NOTL_W-1:0] out_notional_r;

  // Reductions over the row: every cell contributes zero unless selected.
  logic          eq_any;
  logic [QW-1:0] eq_qty;
  logic [PW-1:0] best_p, rd_p;
  logic [QW-1:0] best_q, rd_q;

  always_comb begin
    eq_any = 1'b0;
    eq_qty = '0;
    best_p = '0;
    best_q = '0;
    rd_p   = '0;
    rd_q   = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      eq_any = eq_any | c_eq[i];
      eq_qty = eq_qty | c_eqq[i];
      best_p = best_p | c_bp[i];
      best_q = best_q | c_bq[i];
      rd_p   = rd_p | c_rp[i];
      rd_q   = rd_q | c_rq[i];
    end
  end

  // The ask side keeps its best level in the first cell, the bid side in the
  // last occupied one. Top_n walks away from the best end one cell per result.
  logic [31:0] bid_best, bid_rd;
  assign bid_best = 32'(count_r) - 32'd1;
  assign bid_rd   = 32'(count_r) - 32'd1 - 32'(k_r);
  assign best_idx = side_r ? '0 : bid_best[IW-1:0];
  assign rd_idx   = side_r ? IW'(k_r) : bid_rd[IW-1:0];

  assign ctrl.op     = (state_r == sidelvl_pkg::ST_APPLY) ? op_r : sidelvl_pkg::COP_NONE;
  assign ctrl.look   = (state_r == sidelvl_pkg::ST_LOOK);
  assign ctrl.ge_all = (cmd_r == sidelvl_pkg::CMD_CONSUME) && side_r;
  assign ctrl.price  = p_r;
  assign ctrl.qty    = qv_r;

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
    logic [PW-1:0] lp, rp;
    logic [QW-1:0] lq, rq;
    logic          llt;
    if (g == 0) begin : g_first
      assign lp  = '0;
      assign lq  = '0;
      assign llt = 1'b0;
    end else begin : g_inner_l
      assign lp  = c_price[g-1];
      assign lq  = c_qty[g-1];
      assign llt = c_lt[g-1];
    end
    if (g == MAX_LEVELS - 1) begin : g_last
      assign rp = '0;
      assign rq = '0;
    end else begin : g_inner_r
      assign rp = c_price[g+1];
      assign rq = c_qty[g+1];
    end
    sidelvl_cell #(.IDX(g), .IW(IW), .CW(CW)) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .best_idx    (best_idx),
      .rd_idx      (rd_idx),
      .left_price  (lp),
      .left_qty    (lq),
      .left_lt     (llt),
      .right_price (rp),
      .right_qty   (rq),
      .price_o     (c_price[g]),
      .qty_o       (c_qty[g]),
      .lt_o        (c_lt[g]),
      .eq_o        (c_eq[g]),
      .eq_qty_o    (c_eqq[g]),
      .top_price_o (c_bp[g]),
      .best_qty_o  (c_bq[g]),
      .rd_price_o  (c_rp[g]),
      .rd_qty_o    (c_rq[g])
    );
  end

  // Fetch cycle: the cells have marked the matching level and the insertion
  // point, so the action and its effect on the total are decided here.
  logic          full;
  logic [QW:0]   sat_sum;
  logic [QW-1:0] take;

  assign full    = (count_r == CW'(MAX_LEVELS));
  assign sat_sum = {1'b0, eq_qty} + {1'b0, q_r};
  assign take    = (q_r < bq_r) ? q_r : bq_r;

  always_comb begin
    op_nxt       = sidelvl_pkg::COP_NONE;
    qv_nxt       = q_r;
    sub_nxt      = '0;
    add_nxt      = '0;
    status_nxt   = 1'b0;
    consumed_nxt = '0;
    notional_nxt = '0;
    cnt_new_nxt  = count_r;
    case (cmd_r)
      sidelvl_pkg::CMD_UPSERT, sidelvl_pkg::CMD_ADD: begin
        if (q_r == '0) begin
          if (cmd_r == sidelvl_pkg::CMD_UPSERT && eq_any) begin
            op_nxt      = sidelvl_pkg::COP_DELETE;
            sub_nxt     = eq_qty;
            cnt_new_nxt = count_r - CW'(1);
          end
        end else if (eq_any) begin
          op_nxt  = sidelvl_pkg::COP_SET_EQ;
          qv_nxt  = (cmd_r == sidelvl_pkg::CMD_ADD) ?
                    (sat_sum[QW] ? '1 : sat_sum[QW-1:0]) : q_r;
          sub_nxt = eq_qty;
          add_nxt = qv_nxt;
        end else if (full) begin
          status_nxt = 1'b1;
        end else begin
          op_nxt      = sidelvl_pkg::COP_INSERT;
          add_nxt     = q_r;
          cnt_new_nxt = count_r + CW'(1);
        end
      end
      sidelvl_pkg::CMD_REMOVE: begin
        if (q_r != '0 && eq_any) begin
          if (eq_qty <= q_r) begin
            op_nxt      = sidelvl_pkg::COP_DELETE;
            sub_nxt     = eq_qty;
            cnt_new_nxt = count_r - CW'(1);
          end else begin
            op_nxt  = sidelvl_pkg::COP_SET_EQ;
            qv_nxt  = eq_qty - q_r;
            sub_nxt = q_r;
          end
        end
      end
      sidelvl_pkg::CMD_ERASE: begin
        if (eq_any) begin
          op_nxt      = sidelvl_pkg::COP_DELETE;
          sub_nxt     = eq_qty;
          cnt_new_nxt = count_r - CW'(1);
        end
      end
      sidelvl_pkg::CMD_CONSUME: begin
        if (q_r != '0 && count_r != '0) begin
          consumed_nxt = take;
          notional_nxt = 64'(take) * 64'(bp_r);
          sub_nxt      = take;
          if (take >= bq_r) begin
            // On the bid side the best level is the last one: dropping the
            // count is enough. On the ask side every cell shifts down.
            op_nxt      = side_r ? sidelvl_pkg::COP_DELETE : sidelvl_pkg::COP_NONE;
            cnt_new_nxt = count_r - CW'(1);
          end else begin
            op_nxt = sidelvl_pkg::COP_SET_BEST;
            qv_nxt = bq_r - take;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Number of results, worked out as the apply cycle ends.
  logic [31:0] nlim;
  logic        topn_nxt;
  always_comb begin
    nlim = 32'(n_r);
    if (nlim > 32'(cnt_new_r)) nlim = 32'(cnt_new_r);
    if (nlim > 32'(sidelvl_pkg::MAX_RESULTS)) nlim = 32'(sidelvl_pkg::MAX_RESULTS);
    topn_nxt = (cmd_r == sidelvl_pkg::CMD_TOP_N) && (n_r != '0) && (cnt_new_r != '0);
  end

  logic load, is_last;
  assign load    = (state_r == sidelvl_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign is_last = (k_r + KW'(1) == nres_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sidelvl_pkg::ST_IDLE:  if (in_valid) state_nxt = sidelvl_pkg::ST_LOOK;
      sidelvl_pkg::ST_LOOK:  state_nxt = sidelvl_pkg::ST_FETCH;
      sidelvl_pkg::ST_FETCH: state_nxt = sidelvl_pkg::ST_APPLY;
      sidelvl_pkg::ST_APPLY: state_nxt = sidelvl_pkg::ST_EMIT;
      sidelvl_pkg::ST_EMIT:  if (load && is_last) state_nxt = sidelvl_pkg::ST_IDLE;
      default:               state_nxt = sidelvl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sidelvl_pkg::ST_IDLE;
      side_r      <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) side_r <= cfg_book_side;
      if (state_r == sidelvl_pkg::ST_APPLY) begin
        count_r <= cnt_new_r;
        sum_r   <= sum_r - SW'(sub_r) + SW'(add_r);
      end
      if (!out_valid_r || out_ready) out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sidelvl_pkg::ST_IDLE && in_valid) begin
      cmd_r <= in_command;
      p_r   <= in_price;
      q_r   <= in_quantity;
      n_r   <= in_count;
    end
    if (state_r == sidelvl_pkg::ST_LOOK) begin
      bp_r <= best_p;
      bq_r <= best_q;
    end
    if (state_r == sidelvl_pkg::ST_FETCH) begin
      op_r       <= op_nxt;
      qv_r       <= qv_nxt;
      sub_r      <= sub_nxt;
      add_r      <= add_nxt;
      status_r   <= status_nxt;
      consumed_r <= consumed_nxt;
      notional_r <= notional_nxt;
      cnt_new_r  <= cnt_new_nxt;
    end
    if (state_r == sidelvl_pkg::ST_APPLY) begin
      topn_r <= topn_nxt;
      nres_r <= topn_nxt ? nlim[KW-1:0] : KW'(1);
      k_r    <= '0;
    end
    if (load) begin
      k_r               <= k_r + KW'(1);
      out_status_r      <= status_r;
      out_best_valid_r  <= (count_r != '0);
      out_top_price_r   <= (count_r != '0) ? best_p : '0;
      out_best_size_r   <= (count_r != '0) ? best_q : '0;
      out_total_r       <= (sum_r > SW'(sidelvl_pkg::TOTAL_MAX)) ?
                           sidelvl_pkg::TOTAL_MAX : sum_r[TW-1:0];
      out_consumed_r    <= consumed_r;
      out_notional_r    <= notional_r;
      out_level_valid_r <= topn_r;
      out_level_price_r <= topn_r ? rd_p : '0;
      out_level_size_r  <= topn_r ? rd_q : '0;
      out_last_r        <= is_last;
    end
  end

  assign in_ready           = (state_r == sidelvl_pkg::ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_best_valid     = out_best_valid_r;
  assign out_top_price      = out_top_price_r;
  assign out_best_size      = out_best_size_r;
  assign out_total_quantity = out_total_r;
  assign out_consumed       = out_consumed_r;
  assign out_notional       = out_notional_r;
  assign out_level_valid    = out_level_valid_r;
  assign out_level_price    = out_level_price_r;
  assign out_level_size     = out_level_size_r;
  assign out_last           = out_last_r;

endmodule

// File: rtl/core/sidelvl_checker.sv
`timescale 1ns / 1ps

module sidelvl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_best_valid,
  input logic [31:0] out_top_price,
  input logic [31:0] out_best_size,
  input logic [37:0] out_total_quantity,
  input logic        out_level_valid,
  input logic [31:0] out_level_price,
  input logic [31:0] out_level_size,
  input logic        out_last
);

  // A held result stays on the port.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Results of one item follow each other without a gap.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a result burst");

  // An empty book reports nothing at the best level and no quantity.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_best_valid |->
      out_top_price == 32'd0 && out_best_size == 32'd0 && out_total_quantity == 38'd0)
    else $error("empty book with non-zero best or total");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_level_valid |-> out_level_price == 32'd0 && out_level_size == 32'd0)
    else $error("level fields set without a level");

endmodule

bind order_book_side_levels_unit sidelvl_checker u_sidelvl_checker (.*);
